### sv/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  // Field widths fixed by the item formats
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ATTR_W   = 8;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int CELL_FW  = COL_W + ROW_W;

  // Configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Default geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Register reset values
  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Character codes and cells
  localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0F20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_GOTO  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } tcw_cmd_t;

  // Register word index on the configuration port
  typedef enum logic {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } tcw_reg_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic init_busy;
    logic idle;
  } tcw_status_t;

endpackage

`default_nettype wire

### sv/tcw_if.sv
// Valid/ready channel interfaces for command items and cursor result items.
`default_nettype none

interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CMD_W-1:0]    cmd;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::COL_W-1:0]    column;
  logic [tcw_pkg::ROW_W-1:0]    row;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attribute;

  modport source (output valid, output cmd, output char_code, output column,
                  output row, output cell_attribute, input ready);
  modport sink   (input valid, input cmd, input char_code, input column,
                  input row, input cell_attribute, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::POS_W-1:0]    cursor_position;
  logic [tcw_pkg::COL_W-1:0]    cursor_column;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic [tcw_pkg::CELL_W-1:0]   cell_value;

  modport source (output valid, output cursor_position, output cursor_column,
                  output cursor_row, output cell_value, input ready);
  modport sink   (input valid, input cursor_position, input cursor_column,
                  input cursor_row, input cell_value, output ready);
endinterface

`default_nettype wire

### sv/text_console_writer.sv
// Text console writer top level: color registers, command engine, checks.
//
// Command items enter on in_ch (valid/ready) and each gives exactly one
// result item on out_ch reporting the cursor after the command, plus the
// cell value for a read. Colors are set through the APB-style port
// (word 0 foreground, word 1 background); the user must write them only
// while the block is idle, which the block itself does not enforce.
// A clear blanks the screen, one cell blanked per cycle. For a put char
// that scrolls, the scroll copy reads then writes each cell through the
// single screen RAM port pair, then the bottom row is blanked.
// in_ch.ready is high only while the sequencer is idle; one item is in work
// at a time. After reset the screen RAM is filled with blanks, one cell per
// cycle, before the first item is taken.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and waits in its final step until that register frees.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tcw_in_if.sink                            in_ch,
  tcw_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0]   paddr,
  input  wire logic [tcw_pkg::APB_DW-1:0]   pwdata,
  output logic      [tcw_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int COLOR_W = tcw_pkg::COLOR_W;
  localparam int CHK_W   = tcw_pkg::CELL_FW;
  localparam int POS_W   = tcw_pkg::POS_W;

  logic [COLOR_W-1:0]     fg_r, fg_nxt;
  logic [COLOR_W-1:0]     bg_r, bg_nxt;
  logic                   cfg_wr;
  tcw_pkg::tcw_reg_t      cfg_sel;
  tcw_pkg::tcw_status_t   status;
  logic [CHK_W-1:0]       pos_chk;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = tcw_pkg::tcw_reg_t'(paddr[2]);

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        tcw_pkg::REG_FG: fg_nxt = pwdata[COLOR_W-1:0];
        tcw_pkg::REG_BG: bg_nxt = pwdata[COLOR_W-1:0];
        default:         fg_nxt = fg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      tcw_pkg::REG_FG: prdata = {{(tcw_pkg::APB_DW - COLOR_W){1'b0}}, fg_r};
      tcw_pkg::REG_BG: prdata = {{(tcw_pkg::APB_DW - COLOR_W){1'b0}}, bg_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .color_attr ({bg_r, fg_r}),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .status     (status)
  );

  assign pos_chk = CHK_W'(out_ch.cursor_row) * CHK_W'(COLUMNS) +
                   CHK_W'(out_ch.cursor_column);

  // No item is taken while the screen store is still being filled
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    status.init_busy |-> !in_ch.ready)
    else $error("item accepted during reset fill");

  // One item at a time: an accept is followed by a busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !status.idle)
    else $error("sequencer idle right after accept");

  // Reported cursor stays on the screen
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.cursor_column < COLUMNS) && (out_ch.cursor_row < ROWS)))
    else $error("cursor off screen");

  // Linear cursor agrees with its row and column
  a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cursor_position == pos_chk[POS_W-1:0]))
    else $error("cursor index and row/column disagree");

endmodule

`default_nettype wire

### sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/tcw_engine.sv
// Command sequencer: cursor tracking, screen store walks and result register.
`default_nettype none

module tcw_engine #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  color_attr,
  tcw_in_if.sink                           in_ch,
  tcw_out_if.source                        out_ch,
  output tcw_pkg::tcw_status_t             status
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int COL_W   = tcw_pkg::COL_W;
  localparam int ROW_W   = tcw_pkg::ROW_W;
  localparam int CELL_FW = tcw_pkg::CELL_FW;
  localparam int POS_W   = tcw_pkg::POS_W;
  localparam int CELL_W  = tcw_pkg::CELL_W;

  localparam logic [AW-1:0]    LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0]    SCROLL_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]    SCROLL_END  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0]    COLS_A      = AW'(COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_RDWAIT,
    ST_SC_RD,
    ST_SC_WR,
    ST_FILL,
    ST_RESP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 cnt_r, cnt_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [ROW_W-1:0]              row_r, row_nxt;
  tcw_pkg::tcw_cmd_t             cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]    ch_r, ch_nxt;
  logic [COL_W-1:0]              cin_r, cin_nxt;
  logic [ROW_W-1:0]              rin_r, rin_nxt;
  logic [tcw_pkg::ATTR_W-1:0]    ain_r, ain_nxt;
  logic [CELL_W-1:0]             value_r, value_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]              out_pos_r, out_pos_nxt;
  logic [COL_W-1:0]              out_col_r, out_col_nxt;
  logic [ROW_W-1:0]              out_row_r, out_row_nxt;
  logic [CELL_W-1:0]             out_val_r, out_val_nxt;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [CELL_W-1:0]             mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [CELL_W-1:0]             mem_rdata;

  logic                          in_range;
  logic [CELL_FW-1:0]            cell_full;
  logic [AW-1:0]                 cell_addr;
  logic [CELL_W-1:0]             blank;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_range  = ({1'b0, cin_r} < (COL_W + 1)'(COLUMNS)) &&
                     ({1'b0, rin_r} < (ROW_W + 1)'(ROWS));
  assign cell_full = CELL_FW'(rin_r) * CELL_FW'(COLUMNS) + CELL_FW'(cin_r);
  assign cell_addr = cell_full[AW-1:0];
  assign blank     = {color_attr, tcw_pkg::BLANK_CHAR};

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.cursor_column   = out_col_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cell_value      = out_val_r;

  assign status.init_busy = (state_r == ST_INIT);
  assign status.idle      = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    cin_nxt       = cin_r;
    rin_nxt       = rin_r;
    ain_nxt       = ain_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_val_nxt   = out_val_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = blank;
    mem_raddr     = cnt_r + COLS_A;

    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::RESET_CELL;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = tcw_pkg::tcw_cmd_t'(in_ch.cmd);
          ch_nxt    = in_ch.char_code;
          cin_nxt   = in_ch.column;
          rin_nxt   = in_ch.row;
          ain_nxt   = in_ch.cell_attribute;
          value_nxt = '0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_RESP;
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            priority if (ch_r == tcw_pkg::CH_NUL) begin
              state_nxt = ST_RESP;
            end else if (ch_r == tcw_pkg::CH_BS) begin
              if (idx_r != '0) begin
                idx_nxt = idx_r - AW'(1);
                if (col_r == '0) begin
                  col_nxt = LAST_COL;
                  row_nxt = row_r - ROW_W'(1);
                end else begin
                  col_nxt = col_r - COL_W'(1);
                end
              end
            end else if (ch_r == tcw_pkg::CH_NL) begin
              if (row_r == LAST_ROW) begin
                cnt_nxt   = '0;
                idx_nxt   = SCROLL_BASE;
                col_nxt   = '0;
                row_nxt   = LAST_ROW;
                state_nxt = ST_SC_RD;
              end else begin
                idx_nxt = idx_r + COLS_A - AW'(col_r);
                col_nxt = '0;
                row_nxt = row_r + ROW_W'(1);
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = idx_r;
              mem_wdata = {color_attr, ch_r};
              if (idx_r == LAST_CELL) begin
                cnt_nxt   = '0;
                idx_nxt   = SCROLL_BASE;
                col_nxt   = '0;
                row_nxt   = LAST_ROW;
                state_nxt = ST_SC_RD;
              end else begin
                idx_nxt = idx_r + AW'(1);
                if (col_r == LAST_COL) begin
                  col_nxt = '0;
                  row_nxt = row_r + ROW_W'(1);
                end else begin
                  col_nxt = col_r + COL_W'(1);
                end
              end
            end
          end
          tcw_pkg::CMD_GOTO: begin
            if (in_range) begin
              idx_nxt = cell_addr;
              col_nxt = cin_r;
              row_nxt = rin_r;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            cnt_nxt   = '0;
            idx_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_FILL;
          end
          tcw_pkg::CMD_WRITE: begin
            if (in_range) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr;
              mem_wdata = {ain_r, ch_r};
            end
          end
          tcw_pkg::CMD_READ: begin
            mem_raddr = cell_addr;
            if (in_range) begin
              state_nxt = ST_RDWAIT;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end

      ST_RDWAIT: begin
        value_nxt = mem_rdata;
        state_nxt = ST_RESP;
      end

      // Move each row up: read the cell one row below, then write it here
      ST_SC_RD: begin
        state_nxt = ST_SC_WR;
      end

      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (cnt_r == SCROLL_END) begin
          cnt_nxt   = SCROLL_BASE;
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = ST_SC_RD;
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      // Hold the result until the output register is free
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(idx_r);
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_val_nxt   = value_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    ch_r      <= ch_nxt;
    cin_r     <= cin_nxt;
    rin_r     <= rin_nxt;
    ain_r     <= ain_nxt;
    value_r   <= value_nxt;
    out_pos_r <= out_pos_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

`default_nettype wire
